// ===== src/sadrrip_pkg.sv =====
// Shared constants and types of the streaming-aware DRRIP replacement block.
package sadrrip_pkg;

    localparam int NUM_SETS_DEF       = 2048;
    localparam int NUM_WAYS_DEF       = 16;
    localparam int DELTA_HISTORY_DEF  = 4;
    localparam int LEADER_COUNT_DEF   = 32;
    localparam int DECAY_PERIOD_DEF   = 4096;
    localparam int SELECTOR_BITS_DEF  = 10;

    localparam int DEAD_CTR_W     = 2;
    localparam int RRPV_TOP       = 3;
    localparam int DEAD_TOP       = (DEAD_CTR_W == 2 ? 3 : 1);
    localparam int STREAM_MATCHES = 3;
    localparam int ADDR_W         = 64;
    localparam int IN_DATA_W      = 88;
    localparam int OUT_DATA_W     = 8;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic is_query;
        logic hit;
        logic had_victim;
        logic streaming;
        logic srrip;
        logic chance_zero;
    } way_ctrl_t;

endpackage

// ===== src/sadrrip_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
module sadrrip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sadrrip_way_unit.sv =====
// Per-set way logic: victim search with ageing, hit promotion and fill insertion.
module sadrrip_way_unit #(
    parameter int NUM_WAYS = sadrrip_pkg::NUM_WAYS_DEF
) (
    input  sadrrip_pkg::way_ctrl_t            ctrl,
    input  logic [$clog2(NUM_WAYS)-1:0]       way,
    input  logic [NUM_WAYS-1:0][1:0]          rrpv_in,
    input  logic [NUM_WAYS-1:0][1:0]          dead_in,
    output logic [NUM_WAYS-1:0][1:0]          rrpv_out,
    output logic [NUM_WAYS-1:0][1:0]          dead_out,
    output logic [$clog2(NUM_WAYS)-1:0]       victim
);

    localparam int WAY_W = $clog2(NUM_WAYS);

    logic                     found_dead;
    logic                     found_top;
    logic [1:0]               top;
    logic [1:0]               lift;
    logic [1:0]               ins;
    logic [NUM_WAYS-1:0][1:0] aged;

    always_comb
    begin
        rrpv_out   = rrpv_in;
        dead_out   = dead_in;
        victim     = '0;
        found_dead = 1'b0;
        found_top  = 1'b0;
        top        = 2'd0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found_dead && rrpv_in[w] == 2'(sadrrip_pkg::RRPV_TOP)
                && dead_in[w] == 2'(sadrrip_pkg::DEAD_TOP))
            begin
                found_dead = 1'b1;
                victim     = WAY_W'(w);
            end
            if (rrpv_in[w] > top)
            begin
                top = rrpv_in[w];
            end
        end
        lift = 2'(sadrrip_pkg::RRPV_TOP) - top;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged[w] = rrpv_in[w] + lift;
        end
        // A dead or streaming line goes in at the far position; otherwise the policy decides.
        if (ctrl.streaming || dead_in[way] == 2'(sadrrip_pkg::DEAD_TOP))
        begin
            ins = 2'(sadrrip_pkg::RRPV_TOP);
        end
        else if (ctrl.srrip || ctrl.chance_zero)
        begin
            ins = 2'(sadrrip_pkg::RRPV_TOP - 1);
        end
        else
        begin
            ins = 2'(sadrrip_pkg::RRPV_TOP);
        end

        if (ctrl.is_query)
        begin
            if (!found_dead)
            begin
                rrpv_out = aged;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (!found_top && aged[w] == 2'(sadrrip_pkg::RRPV_TOP))
                    begin
                        found_top = 1'b1;
                        victim    = WAY_W'(w);
                    end
                end
            end
        end
        else if (ctrl.hit)
        begin
            rrpv_out[way] = 2'd0;
            dead_out[way] = 2'd0;
        end
        else
        begin
            rrpv_out[way] = ins;
            dead_out[way] = (ctrl.had_victim && ins == 2'(sadrrip_pkg::RRPV_TOP)) ? 2'd1 : 2'd0;
        end
    end

endmodule

// ===== src/streaming_aware_drrip_replacement.sv =====
// Top level: sequencer, stride detector and line stores of the DRRIP replacement block.
//
// Commands arrive as words on the s_axis channel (tuser = cmd, tdata = set_index, way,
// paddr, had_victim, hit, chance) and each produces exactly one result word on m_axis
// (victim_way, set_streaming). The block takes one word at a time; s_axis_tready is high
// only while the sequencer is idle.
// A query passes from acceptance to its result word through index reduction, one
// registered memory read, the row register, the way unit, then the output register.
// An update also passes through the stride detector, which compares the stored deltas
// one per cycle in one 64-bit comparator. A new command is taken only once the result
// of the previous one has been moved into the output register.
// Index reduction subtracts NUM_SETS or NUM_WAYS repeatedly until both are in range.
// Every DECAY_PERIOD updates, the update first sweeps the line store to age the dead
// counters, reading and then writing back each set.
// After reset a clearing pass writes every set of both stores with s_axis_tready low.
// The result waits in an output register: a stalled receiver does not stop the next
// command from being taken and worked on, only its completion.
module streaming_aware_drrip_replacement #(
    parameter int NUM_SETS       = sadrrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS       = sadrrip_pkg::NUM_WAYS_DEF,
    parameter int DELTA_HISTORY  = sadrrip_pkg::DELTA_HISTORY_DEF,
    parameter int LEADER_COUNT   = sadrrip_pkg::LEADER_COUNT_DEF,
    parameter int DECAY_PERIOD   = sadrrip_pkg::DECAY_PERIOD_DEF,
    parameter int SELECTOR_BITS  = sadrrip_pkg::SELECTOR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // set_index[10:0], way[14:11], paddr[78:15], had_victim[79], hit[80], chance[85:81]
    input  logic [sadrrip_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // victim_way[3:0], set_streaming[4]
    output logic [sadrrip_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int SI_W   = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int PTR_W  = $clog2(DELTA_HISTORY);
    localparam int DC_W   = $clog2(DECAY_PERIOD);
    localparam int AW     = sadrrip_pkg::ADDR_W;
    localparam int LROW_W = 4 * NUM_WAYS;
    localparam int SROW_W = AW + AW * DELTA_HISTORY + PTR_W + 1;
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_DECAY_RD,
        ST_DECAY_WR,
        ST_RD,
        ST_EXEC,
        ST_CMP,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t                                state_reg;
    logic [SI_W-1:0]                       sweep_reg;
    logic                                  cmd_reg;
    logic [10:0]                           sidx_reg;
    logic [3:0]                            way_reg;
    logic [AW-1:0]                         paddr_reg;
    logic                                  hv_reg;
    logic                                  hit_reg;
    logic                                  chance0_reg;
    logic [DC_W-1:0]                       dcnt_reg;
    logic [SELECTOR_BITS-1:0]              sel_reg;
    logic [LROW_W-1:0]                     line_row_reg;
    logic [DELTA_HISTORY-1:0][AW-1:0]      hist_reg;
    logic [PTR_W-1:0]                      ptr_reg;
    logic [PTR_W-1:0]                      idx_reg;
    logic [PTR_W-1:0]                      match_reg;
    logic                                  stream_reg;
    logic                                  m_valid_reg;
    logic [sadrrip_pkg::OUT_DATA_W-1:0]    m_data_reg;
    logic [3:0]                            res_victim_reg;
    logic                                  res_stream_reg;

    logic [SI_W-1:0]                       sset;
    logic [WAY_W-1:0]                      wsel;
    logic                                  sidx_ok;
    logic                                  way_ok;
    logic                                  leader_srrip;
    logic                                  leader_brrip;
    logic                                  fin_stream;

    logic                                  line_we;
    logic [SI_W-1:0]                       line_waddr;
    logic [LROW_W-1:0]                     line_wdata;
    logic [SI_W-1:0]                       line_raddr;
    logic [LROW_W-1:0]                     line_rdata;
    logic [LROW_W-1:0]                     decay_row;
    logic [LROW_W-1:0]                     reset_row;
    logic                                  set_we;
    logic [SROW_W-1:0]                     set_wdata;
    logic [SROW_W-1:0]                     set_rdata;

    logic [AW-1:0]                         rd_last;
    logic [PTR_W-1:0]                      rd_ptr;
    logic [AW-1:0]                         delta;
    logic [DELTA_HISTORY-1:0][AW-1:0]      hist_next;

    sadrrip_pkg::way_ctrl_t                wu_ctrl;
    logic [NUM_WAYS-1:0][1:0]              wu_rrpv;
    logic [NUM_WAYS-1:0][1:0]              wu_dead;
    logic [WAY_W-1:0]                      wu_victim;

    assign sset         = SI_W'(sidx_reg);
    assign wsel         = WAY_W'(way_reg);
    assign sidx_ok      = 32'(sidx_reg) < NUM_SETS;
    assign way_ok       = 32'(way_reg) < NUM_WAYS;
    assign leader_srrip = 32'(sset) < LEADER_COUNT;
    assign leader_brrip = !leader_srrip && (32'(sset) >= NUM_SETS - LEADER_COUNT);
    assign fin_stream   = cmd_reg ? (32'(match_reg) >= sadrrip_pkg::STREAM_MATCHES)
                                  : stream_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Stored set row: last address, delta history, pointer, streaming flag (low to high).
    assign rd_last = set_rdata[AW-1:0];
    assign rd_ptr  = set_rdata[AW + AW * DELTA_HISTORY +: PTR_W];
    assign delta   = (rd_last != '0) ? (paddr_reg - rd_last) : '0;

    always_comb
    begin
        for (int i = 0; i < DELTA_HISTORY; i++)
        begin
            hist_next[i] = (rd_ptr == PTR_W'(i)) ? delta : set_rdata[AW + AW * i +: AW];
        end
    end

    // Line row: re-reference values in the low half, dead counters in the high half.
    assign reset_row = {{(2 * NUM_WAYS){1'b0}}, {NUM_WAYS{2'(sadrrip_pkg::RRPV_TOP)}}};

    always_comb
    begin
        decay_row = line_rdata;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (line_rdata[2 * NUM_WAYS + 2 * w +: 2] != 2'd0)
            begin
                decay_row[2 * NUM_WAYS + 2 * w +: 2] = line_rdata[2 * NUM_WAYS + 2 * w +: 2]
                                                       - 2'd1;
            end
        end
    end

    assign wu_ctrl.is_query    = (cmd_reg == sadrrip_pkg::CMD_QUERY);
    assign wu_ctrl.hit         = hit_reg;
    assign wu_ctrl.had_victim  = hv_reg;
    assign wu_ctrl.streaming   = fin_stream;
    assign wu_ctrl.srrip       = leader_srrip || (!leader_brrip && sel_reg >= SEL_MID);
    assign wu_ctrl.chance_zero = chance0_reg;

    sadrrip_way_unit #(
        .NUM_WAYS (NUM_WAYS)
    ) u_way_unit (
        .ctrl     (wu_ctrl),
        .way      (wsel),
        .rrpv_in  (line_row_reg[2 * NUM_WAYS - 1:0]),
        .dead_in  (line_row_reg[LROW_W - 1:2 * NUM_WAYS]),
        .rrpv_out (wu_rrpv),
        .dead_out (wu_dead),
        .victim   (wu_victim)
    );

    always_comb
    begin
        line_we    = 1'b0;
        line_waddr = sset;
        line_wdata = {wu_dead, wu_rrpv};
        line_raddr = sset;
        unique case (state_reg)
            ST_CLEAR:
            begin
                line_we    = 1'b1;
                line_waddr = sweep_reg;
                line_wdata = reset_row;
            end
            ST_DECAY_RD:
            begin
                line_raddr = sweep_reg;
            end
            ST_DECAY_WR:
            begin
                line_we    = 1'b1;
                line_waddr = sweep_reg;
                line_wdata = decay_row;
            end
            ST_FIN:
            begin
                line_we = 1'b1;
            end
            default:
            begin
                line_we = 1'b0;
            end
        endcase
    end

    assign set_we    = (state_reg == ST_CLEAR) || (state_reg == ST_FIN && cmd_reg);
    assign set_wdata = (state_reg == ST_CLEAR) ? '0
                                               : {fin_stream, ptr_reg, hist_reg, paddr_reg};

    sadrrip_ram #(
        .WIDTH (LROW_W),
        .DEPTH (NUM_SETS)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    sadrrip_ram #(
        .WIDTH (SROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr ((state_reg == ST_CLEAR) ? sweep_reg : sset),
        .wdata (set_wdata),
        .raddr (sset),
        .rdata (set_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            dcnt_reg    <= '0;
            sel_reg     <= SEL_MID;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // In ST_DONE the output register is handled by the state itself.
            if (m_valid_reg && m_axis_tready && state_reg != ST_DONE)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (32'(sweep_reg) == NUM_SETS - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg     <= s_axis_tuser;
                        sidx_reg    <= s_axis_tdata[10:0];
                        way_reg     <= s_axis_tdata[14:11];
                        paddr_reg   <= s_axis_tdata[78:15];
                        hv_reg      <= s_axis_tdata[79];
                        hit_reg     <= s_axis_tdata[80];
                        chance0_reg <= (s_axis_tdata[85:81] == 5'd0);
                        state_reg   <= ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                    // Bring the set and way into range by repeated subtraction.
                    if (!sidx_ok)
                    begin
                        sidx_reg <= sidx_reg - 11'(NUM_SETS);
                    end
                    if (!way_ok)
                    begin
                        way_reg <= way_reg - 4'(NUM_WAYS);
                    end
                    if (sidx_ok && way_ok)
                    begin
                        if (cmd_reg && 32'(dcnt_reg) == DECAY_PERIOD - 1)
                        begin
                            dcnt_reg  <= '0;
                            sweep_reg <= '0;
                            state_reg <= ST_DECAY_RD;
                        end
                        else
                        begin
                            if (cmd_reg)
                            begin
                                dcnt_reg <= dcnt_reg + 1'b1;
                            end
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_DECAY_RD:
                begin
                    state_reg <= ST_DECAY_WR;
                end
                ST_DECAY_WR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    state_reg <= (32'(sweep_reg) == NUM_SETS - 1) ? ST_RD : ST_DECAY_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    line_row_reg <= line_rdata;
                    stream_reg   <= set_rdata[SROW_W-1];
                    hist_reg     <= hist_next;
                    ptr_reg      <= (32'(rd_ptr) == DELTA_HISTORY - 1) ? '0 : rd_ptr + 1'b1;
                    idx_reg      <= PTR_W'(1);
                    match_reg    <= '0;
                    state_reg    <= cmd_reg ? ST_CMP : ST_FIN;
                end
                ST_CMP:
                begin
                    if (hist_reg[0] != '0 && hist_reg[idx_reg] == hist_reg[0])
                    begin
                        match_reg <= match_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(idx_reg) == DELTA_HISTORY - 1)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    res_victim_reg <= cmd_reg ? 4'd0 : 4'(wu_victim);
                    res_stream_reg <= fin_stream;
                    if (cmd_reg && !hit_reg)
                    begin
                        if (leader_srrip && sel_reg != '0)
                        begin
                            sel_reg <= sel_reg - 1'b1;
                        end
                        else if (leader_brrip && sel_reg != SEL_MAX)
                        begin
                            sel_reg <= sel_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_data_reg  <= {3'b000, res_stream_reg, res_victim_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_decay_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE && cmd_reg && sidx_ok && way_ok
         && 32'(dcnt_reg) == DECAY_PERIOD - 1) |=> (state_reg == ST_DECAY_RD))
        else $error("decay sweep did not start on counter wrap");

    a_sel_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (sel_reg == $past(sel_reg)
            || sel_reg == $past(sel_reg) + 1'b1 || sel_reg == $past(sel_reg) - 1'b1))
        else $error("selector moved by more than one step");

    a_line_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        line_we |-> (state_reg == ST_CLEAR || state_reg == ST_DECAY_WR
                     || state_reg == ST_FIN))
        else $error("line store written outside a write state");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (32'(match_reg) <= DELTA_HISTORY - 1))
        else $error("stride match count out of range");

    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_valid_reg && !m_axis_tready) |=> (state_reg == ST_DONE))
        else $error("result left while output register was full");

endmodule
